/* hdl/ctbc_pkg.sv */
// Package with the shared widths, codes and word types of the channel traffic counter bank.
package ctbc_pkg;

  localparam int unsigned CHANNELS_DEF = 64;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned BYTES_IN_W = 40;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CH_W       = 6;
  localparam int unsigned REQ_W      = 32;
  localparam int unsigned BYTE_W     = 48;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_FLUSH  = 1'b1
  } command_e;

  typedef struct packed {
    logic [0:0]            command;
    logic [RAW_W-1:0]      raw_channel;
    logic [BYTES_IN_W-1:0] bytes_sent;
    logic [TIME_W-1:0]     now_seconds;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [REQ_W-1:0]  request_total;
    logic [BYTE_W-1:0] byte_total;
    logic [TIME_W-1:0] interval_start;
    logic [TIME_W-1:0] interval_end;
    logic              has_entry;
    logic              last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rec_read;
    logic rec_write;
    logic flush_start;
    logic scan_read;
    logic scan_skip;
    logic emit_entry;
    logic emit_empty;
  } ctbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;
    logic cur_valid;
    logic rest_any;
    logic above_any;
    logic out_free;
  } ctbc_sts_t;

endpackage

/* hdl/ctbc_ram.sv */
// Generic single-port RAM with a registered read.
module ctbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ctbc_ctrl.sv */
// Controller state machine that sequences record updates and flush walks.
module ctbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctbc_pkg::ctbc_sts_t sts_i,
  output ctbc_pkg::ctbc_cmd_t cmd_o
);
  import ctbc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.is_flush) begin
            cmd_o.flush_start = 1'b1;
            state_d           = ST_SCAN;
          end else begin
            cmd_o.rec_read = 1'b1;
            state_d        = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        cmd_o.rec_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        if (!sts_i.rest_any) begin
          if (sts_i.out_free) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = ST_IDLE;
          end
        end else if (sts_i.cur_valid) begin
          cmd_o.scan_read = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.scan_skip = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_entry = 1'b1;
          state_d          = sts_i.above_any ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* hdl/ctbc_dp.sv */
// Datapath: counter RAM, valid bits, saturating update, flush pointer and output register.
module ctbc_dp #(
  parameter int unsigned CHANNELS = ctbc_pkg::CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctbc_pkg::in_word_t  in_word_i,
  input  ctbc_pkg::ctbc_cmd_t cmd_i,
  output ctbc_pkg::ctbc_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctbc_pkg::out_word_t out_word_o
);
  import ctbc_pkg::*;

  localparam int unsigned PTR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ENT_W = REQ_W + BYTE_W;

  logic [PTR_W-1:0]      ch_q;
  logic [BYTES_IN_W-1:0] bytes_q;
  logic [TIME_W-1:0]     now_q;
  logic [TIME_W-1:0]     last_flush_q;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [CHANNELS-1:0]   valid_q, valid_d;
  logic                  out_valid_q;
  out_word_t             out_word_q;

  logic [PTR_W-1:0]  rec_ch;
  logic [PTR_W-1:0]  ram_addr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [ENT_W-1:0]  ram_wdata;
  logic [REQ_W-1:0]  old_req, new_req;
  logic [BYTE_W-1:0] old_byte, new_byte;
  logic [BYTE_W:0]   byte_sum;
  logic [CHANNELS-1:0] rest_vec;
  logic              out_free;
  logic              load_out;

  // Channel zero and anything out of range fold into channel 0.
  always_comb begin
    if ((in_word_i.raw_channel == '0) || (in_word_i.raw_channel >= RAW_W'(CHANNELS))) begin
      rec_ch = '0;
    end else begin
      rec_ch = in_word_i.raw_channel[PTR_W-1:0];
    end
  end

  always_comb begin
    if (cmd_i.rec_read) begin
      ram_addr = rec_ch;
    end else if (cmd_i.rec_write) begin
      ram_addr = ch_q;
    end else begin
      ram_addr = ptr_q;
    end
  end

  ctbc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rec_write),
    .re_i    (cmd_i.rec_read | cmd_i.scan_read),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // An entry without its valid bit is read as zero, whatever the RAM still holds.
  assign old_req  = valid_q[ch_q] ? ram_rdata[ENT_W-1 -: REQ_W] : '0;
  assign old_byte = valid_q[ch_q] ? ram_rdata[BYTE_W-1:0] : '0;
  assign new_req  = (old_req == '1) ? old_req : old_req + REQ_W'(1);
  assign byte_sum = {1'b0, old_byte} + (BYTE_W + 1)'(bytes_q);
  assign new_byte = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
  assign ram_wdata = {new_req, new_byte};

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.rec_write) begin
      valid_d = valid_q | (CHANNELS'(1) << ch_q);
    end else if (cmd_i.emit_entry) begin
      valid_d = valid_q & ~(CHANNELS'(1) << ptr_q);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.flush_start) begin
      ptr_d = '0;
    end else if (cmd_i.scan_skip || cmd_i.emit_entry) begin
      ptr_d = ptr_q + PTR_W'(1);
    end
  end

  assign rest_vec = valid_q >> ptr_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = cmd_i.emit_entry || cmd_i.emit_empty;

  assign sts_o.is_flush  = (in_word_i.command == CMD_FLUSH);
  assign sts_o.cur_valid = valid_q[ptr_q];
  assign sts_o.rest_any  = |rest_vec;
  assign sts_o.above_any = |(rest_vec >> 1);
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      ptr_q        <= '0;
      last_flush_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
      if (cmd_i.emit_empty || (cmd_i.emit_entry && !sts_o.above_any)) begin
        last_flush_q <= now_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_read) begin
      ch_q    <= rec_ch;
      bytes_q <= in_word_i.bytes_sent;
    end
    if (cmd_i.flush_start) begin
      now_q <= in_word_i.now_seconds;
    end
    if (cmd_i.emit_entry) begin
      out_word_q.channel        <= CH_W'(ptr_q);
      out_word_q.request_total  <= ram_rdata[ENT_W-1 -: REQ_W];
      out_word_q.byte_total     <= ram_rdata[BYTE_W-1:0];
      out_word_q.interval_start <= last_flush_q;
      out_word_q.interval_end   <= now_q;
      out_word_q.has_entry      <= 1'b1;
      out_word_q.last           <= !sts_o.above_any;
    end else if (cmd_i.emit_empty) begin
      out_word_q.channel        <= '0;
      out_word_q.request_total  <= '0;
      out_word_q.byte_total     <= '0;
      out_word_q.interval_start <= last_flush_q;
      out_word_q.interval_end   <= now_q;
      out_word_q.has_entry      <= 1'b0;
      out_word_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A reported channel must be active and is cleared once reported.
  a_emit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_entry |-> valid_q[ptr_q])
    else $error("entry reported for an inactive channel");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_entry |=> !valid_q[$past(ptr_q)])
    else $error("reported channel was not cleared");

  a_empty_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_empty |-> (valid_q == '0))
    else $error("empty report while channels are active");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("output word overwritten before it was taken");

endmodule

/* hdl/channel_traffic_counter_bank_unit.sv */
// Top level of the channel traffic counter bank: controller and datapath.
//
//   Channel  Direction  Handshake               Word
//   in       input      in_valid_i / in_stall_o    ctbc_pkg::in_word_t
//   out      output     out_valid_o / out_stall_i  ctbc_pkg::out_word_t
//
// A record word reads the counter pair of its channel from the single-port counter
// RAM and then, in the update state, writes it back, saturated. A flush word starts
// a walk that skips each inactive channel and reads and reports each active one, as
// it visits channels up to the last active one; it ends once no active channel
// remains, and reports one empty word when none is active. Report words wait in the
// output register while the output is stalled, and the walk pauses with them.
// Reset clears per-channel valid bits at once, so no clearing pass follows it.
module channel_traffic_counter_bank_unit #(
  parameter int unsigned CHANNELS = ctbc_pkg::CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ctbc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctbc_pkg::out_word_t out_word_o
);
  import ctbc_pkg::*;

  // The controller only sees status flags; all payload stays in the datapath.
  ctbc_cmd_t cmd;
  ctbc_sts_t sts;

  ctbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the counters, the valid bit of each channel, the flush
  // pointer, the time of the previous flush and the output register. The last
  // marker is known when an entry is reported because no valid bit lies above it.
  ctbc_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
